>>> hdl/umfv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// umfv_pkg
// Shared types, constants and helpers for the momentum four-vector generator.
// ----------------------------------------------------------------------------
package umfv_pkg;

    localparam int NUM_SPECIES  = 8;
    localparam int IDX_W        = 3;
    localparam int CORDIC_STEPS = 32;
    localparam int SQRT_STEPS   = 33;

    localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
    localparam logic signed [32:0] Q30_ONE   = 33'sd1073741824;
    localparam logic signed [66:0] MAG_MAX   = 67'sd4294967295;
    localparam logic signed [66:0] RND_HALF  = 67'sd536870912;

    localparam logic [2:0] REG_MOM_MIN    = 3'd0;
    localparam logic [2:0] REG_MOM_SPAN   = 3'd1;
    localparam logic [2:0] REG_THETA_MIN  = 3'd2;
    localparam logic [2:0] REG_THETA_SPAN = 3'd3;
    localparam logic [2:0] REG_PHI_MIN    = 3'd4;
    localparam logic [2:0] REG_PHI_SPAN   = 3'd5;
    localparam logic [2:0] REG_SPC_COUNT  = 3'd6;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_GEN  = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_P, S_TH, S_PH, S_IDX, S_CT, S_CT_W, S_CP, S_CP_W,
        S_MPT, S_MPZ, S_MPX, S_MPY, S_MM, S_MP2, S_SQ, S_SQ_W, S_OUT
    } state_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_v;
    } cordic_res_t;

    // atan(2^-i) as a turn fraction times 2^32
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // round(prod / 2^30) with half added, then clamp to +-(2^32-1)
    function automatic logic signed [32:0] q30_round(input logic signed [66:0] prod);
        logic signed [66:0] sh;
        logic signed [32:0] r;
        sh = (prod + RND_HALF) >>> 30;
        if (sh > MAG_MAX)
            r = 33'sh0FFFFFFFF;
        else if (sh < -MAG_MAX)
            r = -33'sh0FFFFFFFF;
        else
            r = sh[32:0];
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/uniform_momentum_four_vector_gen.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uniform_momentum_four_vector_gen
// Maps four uniform fractions to a particle four-momentum and species code.
// ----------------------------------------------------------------------------
// A generate item (tuser = 1) runs four multiplies for the range mapping and
// species pick, two 32-step CORDIC runs (polar angle, then azimuth), six
// multiplies for the components and squares, and a 33-step square root, all
// multiplies on one shared registered multiplier. The input is not ready until
// the result has been taken. A load item (tuser = 0) writes one species entry.
// Config writes are taken at any time but must only be issued when idle.
// ----------------------------------------------------------------------------
module uniform_momentum_four_vector_gen
    import umfv_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // u_mom, u_theta, u_phi, u_type, entry_index, entry_mass, entry_code
    input  wire logic [199:0] s_tdata,
    // mode
    input  wire logic         s_tuser,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // mom_x, mom_y, mom_z, energy, species_index, species_code
    output logic [167:0]      m_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    state_t state_reg, state_next;

    logic [31:0] mom_min_reg, mom_span_reg, theta_min_reg, theta_span_reg;
    logic [31:0] phi_min_reg, phi_span_reg;
    logic [3:0]  spc_count_reg;

    logic [31:0] mass_mem [NUM_SPECIES];
    logic [31:0] code_mem [NUM_SPECIES];

    logic [31:0] u_mom_reg, u_theta_reg, u_phi_reg, u_type_reg;
    logic [31:0] p_reg, theta_reg, phi_reg;
    logic [IDX_W-1:0] idx_reg;
    logic signed [31:0] ct_reg, st_reg, cp_reg, sp_reg;
    logic signed [32:0] pt_reg, px_reg, py_reg, pz_reg;
    logic [63:0] m2_reg;
    logic [64:0] rad_sum;
    logic [32:0] energy_reg;

    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [66:0] prod;

    cordic_res_t cor;
    logic        cor_start;
    logic [31:0] cor_angle;
    logic        sq_start, sq_done;
    logic [32:0] sq_root;

    logic        s_acc;
    logic [32:0] p_sum;
    logic [3:0]  idx_raw;

    assign s_acc     = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_OUT);
    assign cfg_ready = 1'b1;

    umfv_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    umfv_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .angle (cor_angle),
        .res   (cor)
    );

    umfv_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .rad   (rad_sum),
        .done  (sq_done),
        .root  (sq_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mom_min_reg    <= '0;
            mom_span_reg   <= '0;
            theta_min_reg  <= '0;
            theta_span_reg <= '0;
            phi_min_reg    <= '0;
            phi_span_reg   <= '0;
            spc_count_reg  <= 4'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MOM_MIN:    mom_min_reg    <= cfg_data;
                REG_MOM_SPAN:   mom_span_reg   <= cfg_data;
                REG_THETA_MIN:  theta_min_reg  <= cfg_data;
                REG_THETA_SPAN: theta_span_reg <= cfg_data;
                REG_PHI_MIN:    phi_min_reg    <= cfg_data;
                REG_PHI_SPAN:   phi_span_reg   <= cfg_data;
                REG_SPC_COUNT:  spc_count_reg  <= cfg_data[3:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cor_start  = 1'b0;
        cor_angle  = theta_reg;
        sq_start   = 1'b0;
        mul_a      = {2'b00, u_mom_reg};
        mul_b      = {1'b0, mom_span_reg};
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_acc && (s_tuser == MODE_GEN))
                    state_next = S_P;
            end
            S_P:
                state_next = S_TH;
            S_TH:
            begin
                mul_a      = {2'b00, u_theta_reg};
                mul_b      = {1'b0, theta_span_reg};
                state_next = S_PH;
            end
            S_PH:
            begin
                mul_a      = {2'b00, u_phi_reg};
                mul_b      = {1'b0, phi_span_reg};
                state_next = S_IDX;
            end
            S_IDX:
            begin
                mul_a      = {30'd0, spc_count_reg};
                mul_b      = {1'b0, u_type_reg};
                state_next = S_CT;
            end
            S_CT:
            begin
                cor_start  = 1'b1;
                state_next = S_CT_W;
            end
            S_CT_W:
            begin
                if (cor.done)
                    state_next = S_CP;
            end
            S_CP:
            begin
                cor_start  = 1'b1;
                cor_angle  = phi_reg;
                state_next = S_CP_W;
            end
            S_CP_W:
            begin
                if (cor.done)
                    state_next = S_MPT;
            end
            S_MPT:
            begin
                mul_a      = {2'b00, p_reg};
                mul_b      = 33'(st_reg);
                state_next = S_MPZ;
            end
            S_MPZ:
            begin
                mul_a      = {2'b00, p_reg};
                mul_b      = 33'(ct_reg);
                state_next = S_MPX;
            end
            S_MPX:
            begin
                mul_a      = 34'(pt_reg);
                mul_b      = 33'(cp_reg);
                state_next = S_MPY;
            end
            S_MPY:
            begin
                mul_a      = 34'(pt_reg);
                mul_b      = 33'(sp_reg);
                state_next = S_MM;
            end
            S_MM:
            begin
                mul_a      = {2'b00, mass_mem[idx_reg]};
                mul_b      = {1'b0, mass_mem[idx_reg]};
                state_next = S_MP2;
            end
            S_MP2:
            begin
                mul_a      = {2'b00, p_reg};
                mul_b      = {1'b0, p_reg};
                state_next = S_SQ;
            end
            S_SQ:
            begin
                sq_start   = 1'b1;
                state_next = S_SQ_W;
            end
            S_SQ_W:
            begin
                if (sq_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_tready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign p_sum   = {1'b0, mom_min_reg} + {1'b0, prod[63:32]};
    assign idx_raw = prod[35:32];
    // mass^2 + p^2, loaded into the root unit in S_SQ
    assign rad_sum = {1'b0, m2_reg} + {1'b0, prod[63:0]};

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            u_mom_reg   <= s_tdata[31:0];
            u_theta_reg <= s_tdata[63:32];
            u_phi_reg   <= s_tdata[95:64];
            u_type_reg  <= s_tdata[127:96];
            if (s_tuser == MODE_LOAD)
            begin
                mass_mem[s_tdata[130:128]] <= s_tdata[162:131];
                code_mem[s_tdata[130:128]] <= s_tdata[194:163];
            end
        end
        unique case (state_reg)
            S_TH:   p_reg     <= p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
            S_PH:   theta_reg <= theta_min_reg + prod[63:32];
            S_IDX:  phi_reg   <= phi_min_reg + prod[63:32];
            S_CT:
            begin
                if ((idx_raw >= spc_count_reg) || (idx_raw >= 4'(NUM_SPECIES)))
                    idx_reg <= '0;
                else
                    idx_reg <= idx_raw[IDX_W-1:0];
            end
            S_CT_W:
            begin
                if (cor.done)
                begin
                    ct_reg <= cor.cos_v;
                    st_reg <= cor.sin_v;
                end
            end
            S_CP_W:
            begin
                if (cor.done)
                begin
                    cp_reg <= cor.cos_v;
                    sp_reg <= cor.sin_v;
                end
            end
            S_MPZ:  pt_reg  <= q30_round(prod);
            S_MPX:  pz_reg  <= q30_round(prod);
            S_MPY:  px_reg  <= q30_round(prod);
            S_MM:   py_reg  <= q30_round(prod);
            S_MP2:  m2_reg  <= prod[63:0];
            S_SQ_W:
            begin
                if (sq_done)
                    energy_reg <= sq_root;
            end
            default: ;
        endcase
    end

    assign m_tdata = {1'b0, code_mem[idx_reg], idx_reg, energy_reg,
                      pz_reg, py_reg, px_reg};

    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");

    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && (s_tuser == MODE_LOAD)) |=> (state_reg == S_IDLE))
        else $error("load item left idle");

    a_gen_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && (s_tuser == MODE_GEN)) |=> (state_reg == S_P))
        else $error("generate item did not start");

    a_cordic_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        cor.done |-> ((state_reg == S_CT_W) || (state_reg == S_CP_W)))
        else $error("cordic finished outside a wait state");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((idx_reg == '0) || ({1'b0, idx_reg} < spc_count_reg)))
        else $error("species index out of range");

endmodule
`default_nettype wire

>>> hdl/umfv_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// umfv_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module umfv_mul
    import umfv_pkg::*;
(
    input  wire logic               clk,
    input  wire logic signed [33:0] a,
    input  wire logic signed [32:0] b,
    output logic signed [66:0]      prod
);

    logic signed [66:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 67'(a) * 67'(b);
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

>>> hdl/umfv_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// umfv_cordic
// Iterative rotation CORDIC: cosine and sine of a 32-bit turn fraction, Q30.
// ----------------------------------------------------------------------------
module umfv_cordic
    import umfv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] angle,
    output cordic_res_t      res
);

    logic signed [32:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic [4:0]         cnt_reg;
    logic [1:0]         quad_reg;
    logic               busy_reg, done_reg;

    logic signed [32:0] dx, dy;
    logic signed [33:0] at;
    logic signed [31:0] cx, cy;

    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;
    assign at = {2'b00, atan_turn(cnt_reg)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 5'(CORDIC_STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(CORDIC_STEPS - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_X0;
            y_reg    <= '0;
            z_reg    <= {4'b0000, angle[29:0]};
            quad_reg <= angle[31:30];
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

    always_comb
    begin
        if (x_reg > Q30_ONE)
            cx = 32'(Q30_ONE);
        else if (x_reg < -Q30_ONE)
            cx = 32'(-Q30_ONE);
        else
            cx = x_reg[31:0];
        if (y_reg > Q30_ONE)
            cy = 32'(Q30_ONE);
        else if (y_reg < -Q30_ONE)
            cy = 32'(-Q30_ONE);
        else
            cy = y_reg[31:0];
        res.done = done_reg;
        unique case (quad_reg)
            2'd0:
            begin
                res.cos_v = cx;
                res.sin_v = cy;
            end
            2'd1:
            begin
                res.cos_v = -cy;
                res.sin_v = cx;
            end
            2'd2:
            begin
                res.cos_v = -cx;
                res.sin_v = -cy;
            end
            default:
            begin
                res.cos_v = cy;
                res.sin_v = -cx;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/umfv_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// umfv_sqrt
// Bit-pair restoring integer square root, floor, one result bit per cycle.
// ----------------------------------------------------------------------------
module umfv_sqrt
    import umfv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [64:0] rad,
    output logic             done,
    output logic [32:0]      root
);

    logic [65:0] rad_reg;
    logic [36:0] rem_reg;
    logic [32:0] root_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, done_reg;

    logic [36:0] rem_sh, trial;

    assign rem_sh = {rem_reg[34:0], rad_reg[65:64]};
    assign trial  = {2'b00, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 6'(SQRT_STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(SQRT_STEPS - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= {1'b0, rad};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[63:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[31:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[31:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for uniform_momentum_four_vector_gen: species loads,
// directed extremes and random generate items are checked against an in-bench
// fixed-point model of the range mapping, CORDIC sine and cosine, and root.
// ----------------------------------------------------------------------------
module tb;
    import umfv_pkg::*;

    typedef struct {
        bit        mode;
        bit [31:0] u_mom;
        bit [31:0] u_theta;
        bit [31:0] u_phi;
        bit [31:0] u_type;
        bit [2:0]  slot;
        bit [31:0] mass;
        bit [31:0] code;
    } gen_item_t;

    typedef struct packed {
        logic [32:0] px;
        logic [32:0] py;
        logic [32:0] pz;
        logic [32:0] energy;
        logic [2:0]  spc_idx;
        logic [31:0] spc_code;
    } four_vec_t;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t kind;
        gen_item_t item;
        bit [2:0]  reg_idx;
        bit [31:0] reg_val;
        bit        typed;
        four_vec_t vec;
    } stim_row_t;

    localparam bit [31:0] ATAN_TURN [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1, 0
    };
    localparam longint UNIT_Q30 = 64'sd1073741824;
    localparam longint P_LIMIT  = 64'sd4294967295;
    localparam bit [2:0] REG_UNUSED = 3'd7;

    logic         clk;
    logic         rst_n;
    logic [199:0] s_tdata;
    logic         s_tuser;
    logic         s_tvalid;
    logic         s_tready;
    logic [167:0] m_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    bit [31:0] mass_tbl [8];
    bit [31:0] code_tbl [8];
    bit [31:0] p_min, p_span, th_min, th_span, ph_min, ph_span;
    bit [3:0]  spc_count;

    four_vec_t vec_q[$];
    stim_row_t rows[$];
    int        idle_phase;
    int        hold_left;
    int        mismatches;
    int        errors;
    int        n_gen;
    int        n_load;
    int        n_cfg;
    int        n_res;

    uniform_momentum_four_vector_gen u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic longint clamp(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b + 64'sd536870912) >>> 30;
    endfunction

    function automatic void cordic_sincos(input bit [31:0] ang,
                                          output longint c, output longint s);
        longint x, y, z, dx, dy;
        x = 64'sd652032874;
        y = 0;
        z = longint'(ang[29:0]);
        for (int i = 0; i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_TURN[i]);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_TURN[i]);
            end
        end
        x = clamp(x, UNIT_Q30);
        y = clamp(y, UNIT_Q30);
        case (ang[31:30])
            2'd0:    begin c = x;  s = y;  end
            2'd1:    begin c = -y; s = x;  end
            2'd2:    begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
    endfunction

    function automatic four_vec_t four_vector(input gen_item_t it);
        four_vec_t   v;
        bit [63:0]   p;
        bit [31:0]   th, ph;
        bit [63:0]   idx;
        longint      ct, st, cp, sp, pt;
        logic [65:0] sq, c66;
        logic [32:0] r, cand;
        p = 64'(p_min) + ((64'(it.u_mom) * 64'(p_span)) >> 32);
        if (p > 64'hFFFF_FFFF)
            p = 64'hFFFF_FFFF;
        th = 32'(64'(th_min) + ((64'(it.u_theta) * 64'(th_span)) >> 32));
        ph = 32'(64'(ph_min) + ((64'(it.u_phi) * 64'(ph_span)) >> 32));
        cordic_sincos(th, ct, st);
        cordic_sincos(ph, cp, sp);
        pt = clamp(q30_mul(longint'(p), st), P_LIMIT);
        v.px = 33'(clamp(q30_mul(pt, cp), P_LIMIT));
        v.py = 33'(clamp(q30_mul(pt, sp), P_LIMIT));
        v.pz = 33'(clamp(q30_mul(longint'(p), ct), P_LIMIT));
        idx = (64'(spc_count) * 64'(it.u_type)) >> 32;
        if (idx >= 64'(spc_count) || idx >= 8)
            idx = 0;
        sq = 66'(mass_tbl[idx]) * 66'(mass_tbl[idx]) + 66'(p) * 66'(p);
        r = '0;
        for (int b = 32; b >= 0; b--)
        begin
            cand = r | (33'd1 << b);
            c66  = 66'(cand);
            if (c66 * c66 <= sq)
                r = cand;
        end
        v.energy   = r;
        v.spc_idx  = idx[2:0];
        v.spc_code = code_tbl[idx];
        return v;
    endfunction

    task automatic add_item(input gen_item_t it, input bit typed, input four_vec_t v);
        stim_row_t r;
        r.kind  = ROW_ITEM;
        r.item  = it;
        r.typed = typed;
        r.vec   = v;
        rows = {rows, r};
    endtask

    task automatic add_cfg(input bit [2:0] idx, input bit [31:0] val);
        stim_row_t r;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        rows = {rows, r};
    endtask

    task automatic drain();
        while (vec_q.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(input bit [2:0] idx, input bit [31:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_MOM_MIN:    p_min     = val;
            REG_MOM_SPAN:   p_span    = val;
            REG_THETA_MIN:  th_min    = val;
            REG_THETA_SPAN: th_span   = val;
            REG_PHI_MIN:    ph_min    = val;
            REG_PHI_SPAN:   ph_span   = val;
            REG_SPC_COUNT:  spc_count = val[3:0];
            default: ;
        endcase
        n_cfg++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // called at a falling edge; returns at a falling edge with the item taken
    task automatic send(input gen_item_t it, input bit typed, input four_vec_t v);
        int        pct;
        four_vec_t e;
        pct = (idle_phase == 0) ? 21 : (idle_phase == 1) ? 55 : 0;
        while ($urandom_range(99) < pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = it.mode;
        s_tdata  = {5'b0, it.code, it.mass, it.slot, it.u_type, it.u_phi,
                    it.u_theta, it.u_mom};
        do
            @(posedge clk);
        while (!s_tready);
        if (it.mode == MODE_LOAD)
        begin
            mass_tbl[it.slot] = it.mass;
            code_tbl[it.slot] = it.code;
            n_load++;
        end
        else
        begin
            e = typed ? v : four_vector(it);
            vec_q = {vec_q, e};
            n_gen++;
        end
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    function automatic bit [31:0] pick32();
        case ($urandom_range(3))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic gen_item_t rand_item();
        gen_item_t it;
        it.mode    = ($urandom_range(99) < 15) ? MODE_LOAD : MODE_GEN;
        it.u_mom   = ($urandom_range(9) == 0) ? pick32() : $urandom;
        it.u_theta = ($urandom_range(9) == 0) ? pick32() : $urandom;
        it.u_phi   = ($urandom_range(9) == 0) ? pick32() : $urandom;
        it.u_type  = ($urandom_range(9) == 0) ? pick32() : $urandom;
        it.slot    = $urandom_range(7);
        it.mass    = ($urandom_range(9) == 0) ? pick32() : $urandom;
        it.code    = $urandom;
        return it;
    endfunction

    // receive side
    initial
    begin
        four_vec_t got, want;
        int        pct;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.px       = m_tdata[32:0];
                got.py       = m_tdata[65:33];
                got.pz       = m_tdata[98:66];
                got.energy   = m_tdata[131:99];
                got.spc_idx  = m_tdata[134:132];
                got.spc_code = m_tdata[166:135];
                n_res++;
                if (vec_q.size() == 0)
                begin
                    errors++;
                    $display("unexpected result: %h", m_tdata);
                end
                else
                begin
                    want = vec_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch px %h/%h py %h/%h pz %h/%h",
                                     want.px, got.px, want.py, got.py,
                                     want.pz, got.pz);
                            $display("  e %h/%h idx %0d/%0d code %h/%h",
                                     want.energy, got.energy, want.spc_idx,
                                     got.spc_idx, want.spc_code, got.spc_code);
                        end
                    end
                end
            end
            @(negedge clk);
            pct = (idle_phase == 0) ? 55 : (idle_phase == 1) ? 21 : 0;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready = 1'b0;
            end
            else
                m_tready = ($urandom_range(99) >= pct);
        end
    end

    initial
    begin
        #20_000_000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        gen_item_t it;
        four_vec_t v;
        int        total;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        idle_phase = 0;
        hold_left  = 0;
        p_min = 0; p_span = 0; th_min = 0; th_span = 0; ph_min = 0; ph_span = 0;
        spc_count = 1;

        // reset config: p = 0, so only energy (mass of slot 0) and code remain
        it = '{MODE_LOAD, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h8000_0000};
        add_item(it, 0, v);
        it = '{MODE_LOAD, 0, 0, 0, 0, 1, 32'h0, 32'h7FFF_FFFF};
        add_item(it, 0, v);
        for (int k = 2; k < 8; k++)
        begin
            it = '{MODE_LOAD, 0, 0, 0, 0, k[2:0], $urandom, $urandom};
            add_item(it, 0, v);
        end
        v = '{33'd0, 33'd0, 33'd0, 33'hFFFF_FFFF, 3'd0, 32'h8000_0000};
        it = '{MODE_GEN, 0, 0, 0, 0, 0, 0, 0};
        add_item(it, 1, v);
        it = '{MODE_GEN, '1, '1, '1, '1, '1, '1, '1};
        add_item(it, 1, v);
        // saturated momentum, wrapped angles, all slots
        add_cfg(REG_MOM_MIN, 32'hFFFF_FFFF);
        add_cfg(REG_MOM_SPAN, 32'hFFFF_FFFF);
        add_cfg(REG_THETA_MIN, 32'h8000_0000);
        add_cfg(REG_THETA_SPAN, 32'h8000_0000);
        add_cfg(REG_PHI_MIN, 32'h8000_0000);
        add_cfg(REG_PHI_SPAN, 32'hFFFF_FFFF);
        add_cfg(REG_SPC_COUNT, 32'd8);
        add_cfg(REG_UNUSED, 32'h1234_5678);
        it = '{MODE_GEN, 0, 0, 0, 0, 0, 0, 0};
        add_item(it, 0, v);
        it = '{MODE_GEN, '1, '1, '1, '1, 0, 0, 0};
        add_item(it, 0, v);
        it = '{MODE_GEN, 32'h8000_0000, 32'h4000_0000, 32'hC000_0000,
               32'hE000_0000, 0, 0, 0};
        add_item(it, 0, v);
        add_cfg(REG_MOM_MIN, 32'd0);
        add_cfg(REG_SPC_COUNT, 32'd0);
        it = '{MODE_GEN, '1, 32'h2000_0000, 32'h6000_0000, '1, 0, 0, 0};
        add_item(it, 0, v);
        add_cfg(REG_SPC_COUNT, 32'd15);
        it = '{MODE_GEN, 32'h1234_5678, 0, '1, '1, 0, 0, 0};
        add_item(it, 0, v);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
            begin
                drain();
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            end
            else
                send(rows[i].item, rows[i].typed, rows[i].vec);
        end

        total = 0;
        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            write_reg(REG_MOM_MIN, ($urandom_range(2) == 0) ? pick32() : $urandom_range(65535));
            write_reg(REG_MOM_SPAN, pick32());
            write_reg(REG_THETA_MIN, ($urandom_range(3) == 0) ? pick32()
                                                              : $urandom_range(32'h8000_0000));
            write_reg(REG_THETA_SPAN, ($urandom_range(3) == 0) ? pick32()
                                                               : $urandom_range(32'h8000_0000));
            write_reg(REG_PHI_MIN, pick32());
            write_reg(REG_PHI_SPAN, pick32());
            write_reg(REG_SPC_COUNT, ($urandom_range(4) == 0) ? $urandom_range(15)
                                                              : $urandom_range(1, 8));
            for (int k = 0; k < 125; k++)
            begin
                idle_phase = (total < 333) ? 0 : (total < 666) ? 1 : 2;
                if (total == 100)
                    hold_left = 600;
                if (total == 500)
                    drain();
                send(rand_item(), 0, v);
                total++;
            end
        end

        drain();
        repeat (200) @(negedge clk);
        if (vec_q.size() != 0)
        begin
            errors++;
            $display("%0d results never arrived", vec_q.size());
        end
        $display("covered %0d generate and %0d load items, %0d register writes,",
                 n_gen, n_load, n_cfg);
        $display("%0d results checked, %0d mismatches", n_res, mismatches);
        if (errors == 0 && mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
